>>> rtl/core/sapb_pkg.sv
// ---------------------------------------------------------------------------
// sapb_pkg
// Types, codes and parse step functions for the SAO/ALF CTU prefix bin parser.
// ---------------------------------------------------------------------------
package sapb_pkg;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_SAO_TYPE     = 4'd1,
      PH_SAO_KIND     = 4'd2,
      PH_SAO_OFFSET   = 4'd3,
      PH_SAO_SIGN     = 4'd4,
      PH_SAO_BAND     = 4'd5,
      PH_SAO_EO       = 4'd6,
      PH_ALF_CTB      = 4'd7,
      PH_ALF_TEMP     = 4'd8,
      PH_ALF_TB_FIX   = 4'd9,
      PH_ALF_TB_EXTRA = 4'd10,
      PH_DONE         = 4'd11
   } phase_type;

   // next bin kind codes
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_SAO_TYPE = 3'd1;
   localparam logic [2:0] KIND_ALF_CTB  = 3'd2;
   localparam logic [2:0] KIND_ALF_TEMP = 3'd3;
   localparam logic [2:0] KIND_BYPASS   = 3'd4;

   // sao modes
   localparam logic [1:0] SAO_OFF  = 2'd0;
   localparam logic [1:0] SAO_BAND = 2'd1;
   localparam logic [1:0] SAO_EDGE = 2'd2;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_SEQ   = 2'd1;
   localparam logic [1:0] ERR_ALF   = 2'd2;

   // request modes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BIN   = 1'b1;

   // component indexes
   localparam logic [1:0] COMP_Y  = 2'd0;
   localparam logic [1:0] COMP_CB = 2'd1;
   localparam logic [1:0] COMP_CR = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_STREAM_VALID   = 3'd0;
   localparam logic [2:0] CSR_SAO_LUMA_ON    = 3'd1;
   localparam logic [2:0] CSR_SAO_CHROMA_ON  = 3'd2;
   localparam logic [2:0] CSR_SAMPLE_DEPTH   = 3'd3;
   localparam logic [2:0] CSR_ALF_ON         = 3'd4;
   localparam logic [2:0] CSR_ALF_UNSUPPORTED = 3'd5;
   localparam logic [2:0] CSR_ALF_SEQ_USE    = 3'd6;
   localparam logic [2:0] CSR_LUMA_APS_COUNT = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   localparam logic [4:0] DEPTH_RESET  = 5'd8;
   localparam logic [4:0] TB_FIXED_MAX = 5'd16;
   localparam logic [7:0] SAO_CNT_MAX  = 8'd255;
   localparam logic [3:0] ALF_CNT_MAX  = 4'd15;
   localparam logic [2:0] BAND_POS_BITS = 3'd5;
   localparam logic [2:0] EO_CLASS_BITS = 3'd2;

   typedef struct packed {
      logic       stream_valid;
      logic       sao_luma_on;
      logic       sao_chroma_on;
      logic [4:0] sample_bit_depth;
      logic       alf_on;
      logic       alf_unsupported;
      logic       alf_seq_use;
      logic [2:0] luma_aps_count;
   } cfg_type;

   typedef struct packed {
      phase_type       phase;
      logic [1:0]      comp;
      logic [1:0]      cb_mode;
      logic [1:0]      cur_mode;
      logic [1:0]      off_idx;
      logic [4:0]      unary;
      logic [3:0][4:0] store;
      logic [4:0]      acc;
      logic [2:0]      left;
      logic [7:0]      sao_cnt;
      logic [3:0]      alf_cnt;
      logic [1:0]      luma_mode;
      logic [1:0]      chroma_mode;
      logic            alf_luma;
      logic            alf_temp;
      logic [1:0]      err;
      logic [19:0]     luma_pack;
      logic [4:0]      band_pos;
      logic [4:0]      tb_max;
   } st_type;

   typedef struct packed {
      logic [2:0]  next_bin_kind;
      logic        done_res;
      logic [1:0]  error_code;
      logic [1:0]  luma_sao_mode;
      logic [1:0]  chroma_sao_mode;
      logic [19:0] luma_offsets;
      logic [4:0]  luma_band_position;
      logic        alf_luma_flag;
      logic        alf_temporal_flag;
      logic [7:0]  sao_bin_count;
      logic [3:0]  alf_bin_count;
   } res_type;

   // largest truncated-unary offset for a bit depth
   function automatic logic [4:0] max_q(input logic [4:0] depth);
      logic [4:0] q;
      case (depth) inside
         [5'd0:5'd5]: q = 5'd0;
         5'd6:        q = 5'd1;
         5'd7:        q = 5'd3;
         5'd8:        q = 5'd7;
         5'd9:        q = 5'd15;
         default:     q = 5'd31;
      endcase
      return q;
   endfunction

   function automatic logic [2:0] tb_thresh(input logic [4:0] n);
      logic [2:0] t;
      if (n >= 5'd16)     t = 3'd4;
      else if (n >= 5'd8) t = 3'd3;
      else if (n >= 5'd4) t = 3'd2;
      else                t = 3'd1;
      return t;
   endfunction

   function automatic st_type f_finish(input st_type s, input logic [1:0] e);
      st_type r;
      r       = s;
      r.err   = e;
      r.phase = PH_DONE;
      return r;
   endfunction

   function automatic st_type f_alf_begin(input st_type s, input cfg_type c);
      st_type r;
      r = s;
      if (!c.alf_on)             r = f_finish(s, ERR_OK);
      else if (c.alf_unsupported) r = f_finish(s, ERR_ALF);
      else if (!c.alf_seq_use)   r = f_finish(s, ERR_OK);
      else                       r.phase = PH_ALF_CTB;
      return r;
   endfunction

   function automatic st_type f_tb_start(input st_type s, input logic [4:0] n);
      st_type r;
      r = s;
      if (n <= 5'd1) begin
         r = f_finish(s, ERR_OK);
      end else begin
         r.tb_max = n;
         r.left   = tb_thresh(n);
         r.acc    = 5'd0;
         r.phase  = PH_ALF_TB_FIX;
      end
      return r;
   endfunction

   // first nonzero offset from start onwards wants a sign bin
   function automatic st_type f_sign_scan(input st_type s, input logic [2:0] start);
      st_type r;
      logic   found;
      r     = s;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!found && (3'(i) >= start) && (s.store[i] != 5'd0)) begin
            r.off_idx = 2'(i);
            r.phase   = PH_SAO_SIGN;
            found     = 1'b1;
         end
      end
      if (!found) begin
         r.left  = BAND_POS_BITS;
         r.acc   = 5'd0;
         r.phase = PH_SAO_BAND;
      end
      return r;
   endfunction

   // cr reuses the cb mode and never reads edge classes
   function automatic st_type f_cr_begin(input st_type s, input cfg_type c);
      st_type r;
      r          = s;
      r.comp     = COMP_CR;
      r.cur_mode = s.cb_mode;
      if (r.cur_mode == SAO_OFF) begin
         r = f_alf_begin(r, c);
      end else begin
         r.store   = '0;
         r.off_idx = 2'd0;
         r.unary   = 5'd0;
         if (max_q(c.sample_bit_depth) != 5'd0) r.phase = PH_SAO_OFFSET;
         else if (r.cur_mode == SAO_BAND)       r = f_sign_scan(r, 3'd0);
         else                                   r = f_alf_begin(r, c);
      end
      return r;
   endfunction

   function automatic st_type f_next_comp(input st_type s, input cfg_type c);
      st_type     r;
      logic [1:0] last;
      r    = s;
      last = c.sao_chroma_on ? COMP_CR : COMP_Y;
      if (s.comp >= last) begin
         r = f_alf_begin(s, c);
      end else if (s.comp == COMP_Y) begin
         r.comp  = COMP_CB;
         r.phase = PH_SAO_TYPE;
      end else begin
         r = f_cr_begin(s, c);
      end
      return r;
   endfunction

   function automatic st_type f_after_offsets(input st_type s, input cfg_type c);
      st_type r;
      r = s;
      if (s.comp == COMP_Y) r.luma_pack = s.store;
      if (s.cur_mode == SAO_BAND) begin
         r = f_sign_scan(r, 3'd0);
      end else if (s.comp != COMP_CR) begin
         r.left  = EO_CLASS_BITS;
         r.acc   = 5'd0;
         r.phase = PH_SAO_EO;
      end else begin
         r = f_next_comp(r, c);
      end
      return r;
   endfunction

   function automatic st_type f_begin_mode(input st_type s, input logic [1:0] m,
                                           input cfg_type c);
      st_type r;
      r          = s;
      r.cur_mode = m;
      if (s.comp == COMP_Y) r.luma_mode = m;
      if (s.comp == COMP_CB) begin
         r.chroma_mode = m;
         r.cb_mode     = m;
      end
      if (m == SAO_OFF) begin
         r = f_next_comp(r, c);
      end else begin
         r.store   = '0;
         r.off_idx = 2'd0;
         r.unary   = 5'd0;
         if (max_q(c.sample_bit_depth) == 5'd0) r = f_after_offsets(r, c);
         else                                   r.phase = PH_SAO_OFFSET;
      end
      return r;
   endfunction

   function automatic st_type f_store_offset(input st_type s, input logic [4:0] v,
                                             input cfg_type c);
      st_type r;
      r                = s;
      r.store[s.off_idx] = v;
      if (s.off_idx == 2'd3) begin
         r = f_after_offsets(r, c);
      end else begin
         r.off_idx = s.off_idx + 2'd1;
         r.unary   = 5'd0;
      end
      return r;
   endfunction

   function automatic st_type f_start(input cfg_type c);
      st_type r;
      r       = '0;
      r.phase = PH_IDLE;
      if (!c.stream_valid) begin
         r = f_finish(r, ERR_SEQ);
      end else if (c.sao_luma_on) begin
         r.comp  = COMP_Y;
         r.phase = PH_SAO_TYPE;
      end else if (c.sao_chroma_on) begin
         r.comp  = COMP_CB;
         r.phase = PH_SAO_TYPE;
      end else begin
         r = f_alf_begin(r, c);
      end
      return r;
   endfunction

   function automatic st_type f_take_bin(input st_type s, input logic b, input cfg_type c);
      st_type     r;
      logic [5:0] u;
      logic [2:0] th;
      r  = s;
      th = tb_thresh(s.tb_max);
      u  = (6'd2 << th) - {1'b0, s.tb_max};
      if (s.phase inside {[PH_SAO_TYPE:PH_SAO_EO]}) begin
         if (s.sao_cnt < SAO_CNT_MAX) r.sao_cnt = s.sao_cnt + 8'd1;
      end else if (s.phase inside {[PH_ALF_CTB:PH_ALF_TB_EXTRA]}) begin
         if (s.alf_cnt < ALF_CNT_MAX) r.alf_cnt = s.alf_cnt + 4'd1;
      end
      case (s.phase)
         PH_SAO_TYPE: begin
            if (b) r.phase = PH_SAO_KIND;
            else   r = f_begin_mode(r, SAO_OFF, c);
         end
         PH_SAO_KIND: begin
            r = f_begin_mode(r, b ? SAO_EDGE : SAO_BAND, c);
         end
         PH_SAO_OFFSET: begin
            if (!b) begin
               r = f_store_offset(r, s.unary, c);
            end else begin
               r.unary = s.unary + 5'd1;
               if (r.unary >= max_q(c.sample_bit_depth)) r = f_store_offset(r, r.unary, c);
            end
         end
         PH_SAO_SIGN: begin
            r = f_sign_scan(r, {1'b0, s.off_idx} + 3'd1);
         end
         PH_SAO_BAND, PH_SAO_EO: begin
            r.acc = {s.acc[3:0], b};
            if (s.left != 3'd0) r.left = s.left - 3'd1;
            if (r.left == 3'd0) begin
               if (s.phase == PH_SAO_BAND && s.comp == COMP_Y) r.band_pos = r.acc;
               r = f_next_comp(r, c);
            end
         end
         PH_ALF_CTB: begin
            if (!b) begin
               r = f_finish(r, ERR_OK);
            end else begin
               r.alf_luma = 1'b1;
               if (c.luma_aps_count != 3'd0) r.phase = PH_ALF_TEMP;
               else                          r = f_tb_start(r, TB_FIXED_MAX);
            end
         end
         PH_ALF_TEMP: begin
            if (b) begin
               r.alf_temp = 1'b1;
               if (c.luma_aps_count > 3'd1) r = f_tb_start(r, {2'b00, c.luma_aps_count});
               else                         r = f_finish(r, ERR_OK);
            end else begin
               r = f_tb_start(r, TB_FIXED_MAX);
            end
         end
         PH_ALF_TB_FIX: begin
            r.acc = {s.acc[3:0], b};
            if (s.left != 3'd0) r.left = s.left - 3'd1;
            if (r.left == 3'd0) begin
               if ({1'b0, r.acc} >= u) r.phase = PH_ALF_TB_EXTRA;
               else                    r = f_finish(r, ERR_OK);
            end
         end
         PH_ALF_TB_EXTRA: begin
            r = f_finish(r, ERR_OK);
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   function automatic res_type f_result(input st_type s);
      res_type o;
      logic    done;
      o    = '0;
      done = (s.phase == PH_DONE);
      case (s.phase)
         PH_SAO_TYPE:      o.next_bin_kind = KIND_SAO_TYPE;
         PH_ALF_CTB:       o.next_bin_kind = KIND_ALF_CTB;
         PH_ALF_TEMP:      o.next_bin_kind = KIND_ALF_TEMP;
         PH_IDLE, PH_DONE: o.next_bin_kind = KIND_NONE;
         default:          o.next_bin_kind = KIND_BYPASS;
      endcase
      o.done_res = done;
      if (done) begin
         o.error_code         = s.err;
         o.luma_sao_mode      = s.luma_mode;
         o.chroma_sao_mode    = s.chroma_mode;
         o.luma_offsets       = s.luma_pack;
         o.luma_band_position = s.band_pos;
         o.alf_luma_flag      = s.alf_luma;
         o.alf_temporal_flag  = s.alf_temp;
         o.sao_bin_count      = s.sao_cnt;
         o.alf_bin_count      = s.alf_cnt;
      end
      return o;
   endfunction

endpackage

>>> rtl/core/sapb_if.sv
// ---------------------------------------------------------------------------
// sapb_if
// Valid/ready channels for parser requests and parser responses.
// ---------------------------------------------------------------------------
interface sapb_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic bin_value;

   modport source (output valid, output mode, output bin_value, input ready);
   modport sink   (input valid, input mode, input bin_value, output ready);
endinterface

interface sapb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  next_bin_kind;
   logic        done_res;
   logic [1:0]  error_code;
   logic [1:0]  luma_sao_mode;
   logic [1:0]  chroma_sao_mode;
   logic [19:0] luma_offsets;
   logic [4:0]  luma_band_position;
   logic        alf_luma_flag;
   logic        alf_temporal_flag;
   logic [7:0]  sao_bin_count;
   logic [3:0]  alf_bin_count;

   modport source (output valid, output next_bin_kind, output done_res, output error_code,
                   output luma_sao_mode, output chroma_sao_mode, output luma_offsets,
                   output luma_band_position, output alf_luma_flag,
                   output alf_temporal_flag, output sao_bin_count, output alf_bin_count,
                   input ready);
   modport sink   (input valid, input next_bin_kind, input done_res, input error_code,
                   input luma_sao_mode, input chroma_sao_mode, input luma_offsets,
                   input luma_band_position, input alf_luma_flag,
                   input alf_temporal_flag, input sao_bin_count, input alf_bin_count,
                   output ready);
endinterface

>>> rtl/core/sao_alf_ctu_prefix_bin_parser_unit.sv
// ---------------------------------------------------------------------------
// sao_alf_ctu_prefix_bin_parser_unit
// SAO and ALF CTU prefix syntax parser driven by externally decoded bins.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one item per transfer: mode 0 opens the parse of a CTU
//   prefix, mode 1 delivers one decoded bin. Every request gives exactly one
//   response on rsp_if naming the kind of bin wanted next; once done_res is
//   set the summary fields hold the parsed SAO modes, offsets, band
//   position, ALF flags, error code and bin counts.
//   csr_wr_en/csr_index/csr_wdata write the sequence and slice settings;
//   write them only while no request is outstanding.
//   A request is held in the request register and its response in the
//   response register. While the receiver does not stall, a request is
//   taken every cycle: the request register feeds one step of parse logic
//   whose output lands in the response register, and the parse state
//   register closes the loop for the next bin in the same cycle.
//   Reset clears the parse state to idle, empties both registers and sets
//   the settings to their defaults (bit depth 8, everything else off).
//   When the receiver stalls, the response is held and the request register
//   keeps one more item; req_if.ready then drops until rsp_if.ready returns.
// ---------------------------------------------------------------------------
module sao_alf_ctu_prefix_bin_parser_unit (
   input  logic                             clock,
   input  logic                             reset,
   sapb_req_if.sink                         req_if,
   sapb_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [sapb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sapb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sapb_pkg::*;

   cfg_type cfg_ff;
   logic    in_valid_ff;
   logic    in_valid_in;
   logic    in_mode_ff;
   logic    in_bin_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   res_type out_res_ff;
   res_type step_res;
   logic    advance;
   logic    step_en;
   logic    req_xfer;

   assign advance  = !out_valid_ff || rsp_if.ready;
   assign step_en  = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer = req_if.valid && req_if.ready;

   always_comb begin
      if (req_xfer)     in_valid_in = 1'b1;
      else if (step_en) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
      if (step_en)           out_valid_in = 1'b1;
      else if (rsp_if.ready) out_valid_in = 1'b0;
      else                   out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= req_if.mode;
         in_bin_ff  <= req_if.bin_value;
      end
      if (step_en) out_res_ff <= step_res;
   end

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{stream_valid: 1'b0, sao_luma_on: 1'b0, sao_chroma_on: 1'b0,
                     sample_bit_depth: DEPTH_RESET, alf_on: 1'b0,
                     alf_unsupported: 1'b0, alf_seq_use: 1'b0,
                     luma_aps_count: 3'd0};
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STREAM_VALID:    cfg_ff.stream_valid     <= csr_wdata[0];
            CSR_SAO_LUMA_ON:     cfg_ff.sao_luma_on      <= csr_wdata[0];
            CSR_SAO_CHROMA_ON:   cfg_ff.sao_chroma_on    <= csr_wdata[0];
            CSR_SAMPLE_DEPTH:    cfg_ff.sample_bit_depth <= csr_wdata;
            CSR_ALF_ON:          cfg_ff.alf_on           <= csr_wdata[0];
            CSR_ALF_UNSUPPORTED: cfg_ff.alf_unsupported  <= csr_wdata[0];
            CSR_ALF_SEQ_USE:     cfg_ff.alf_seq_use      <= csr_wdata[0];
            CSR_LUMA_APS_COUNT:  cfg_ff.luma_aps_count   <= csr_wdata[2:0];
            default:             cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   sapb_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .step_mode (in_mode_ff),
      .step_bin  (in_bin_ff),
      .cfg       (cfg_ff),
      .step_res  (step_res)
   );

   assign rsp_if.valid              = out_valid_ff;
   assign rsp_if.next_bin_kind      = out_res_ff.next_bin_kind;
   assign rsp_if.done_res           = out_res_ff.done_res;
   assign rsp_if.error_code         = out_res_ff.error_code;
   assign rsp_if.luma_sao_mode      = out_res_ff.luma_sao_mode;
   assign rsp_if.chroma_sao_mode    = out_res_ff.chroma_sao_mode;
   assign rsp_if.luma_offsets       = out_res_ff.luma_offsets;
   assign rsp_if.luma_band_position = out_res_ff.luma_band_position;
   assign rsp_if.alf_luma_flag      = out_res_ff.alf_luma_flag;
   assign rsp_if.alf_temporal_flag  = out_res_ff.alf_temporal_flag;
   assign rsp_if.sao_bin_count      = out_res_ff.sao_bin_count;
   assign rsp_if.alf_bin_count      = out_res_ff.alf_bin_count;

endmodule

>>> rtl/core/sapb_parse_core.sv
// ---------------------------------------------------------------------------
// sapb_parse_core
// Parse state register and the combinational step over one start or bin.
// ---------------------------------------------------------------------------
module sapb_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              step_mode,
   input  logic              step_bin,
   input  sapb_pkg::cfg_type cfg,
   output sapb_pkg::res_type step_res
);
   import sapb_pkg::*;

   st_type st_ff;
   st_type st_in;

   always_comb begin
      if (step_mode == REQ_START) st_in = f_start(cfg);
      else                        st_in = f_take_bin(st_ff, step_bin, cfg);
   end

   // result reflects the state left by this step
   assign step_res = f_result(st_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

endmodule

>>> rtl/core/sapb_checker.sv
// ---------------------------------------------------------------------------
// sapb_checker
// Port-level checks on the parser response channel, bound to the top level.
// ---------------------------------------------------------------------------
module sapb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  next_bin_kind,
   input logic        done_res,
   input logic [1:0]  error_code,
   input logic [1:0]  luma_sao_mode,
   input logic [1:0]  chroma_sao_mode,
   input logic [19:0] luma_offsets,
   input logic        alf_luma_flag,
   input logic [7:0]  sao_bin_count,
   input logic [3:0]  alf_bin_count
);
   import sapb_pkg::*;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // summary fields stay zero until the parse is finished
   a_summary_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> error_code == ERR_OK && luma_sao_mode == SAO_OFF &&
         chroma_sao_mode == SAO_OFF && luma_offsets == 20'd0 &&
         sao_bin_count == 8'd0 && alf_bin_count == 4'd0)
      else $error("summary field set before parse end");

   a_done_no_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> next_bin_kind == KIND_NONE)
      else $error("bin requested after parse end");

   // invalid sequence aborts before any syntax is read
   a_seq_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code == ERR_SEQ |-> sao_bin_count == 8'd0 &&
         alf_bin_count == 4'd0 && !alf_luma_flag && luma_sao_mode == SAO_OFF)
      else $error("syntax parsed despite invalid sequence state");

endmodule

bind sao_alf_ctu_prefix_bin_parser_unit sapb_checker u_sapb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .next_bin_kind   (rsp_if.next_bin_kind),
   .done_res        (rsp_if.done_res),
   .error_code      (rsp_if.error_code),
   .luma_sao_mode   (rsp_if.luma_sao_mode),
   .chroma_sao_mode (rsp_if.chroma_sao_mode),
   .luma_offsets    (rsp_if.luma_offsets),
   .alf_luma_flag   (rsp_if.alf_luma_flag),
   .sao_bin_count   (rsp_if.sao_bin_count),
   .alf_bin_count   (rsp_if.alf_bin_count)
);
